[src/packed_yuv422_to_argb_defines.svh]
// Assertion macros for the packed 4:2:2 to ARGB converter.
// No dependencies; included by the files that carry concurrent checks.
`ifndef PACKED_YUV422_TO_ARGB_DEFINES_SVH
`define PACKED_YUV422_TO_ARGB_DEFINES_SVH

`ifndef ASSERT_OFF
// check a property at each rising edge, muted while reset is active
`define Y2A_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// check a property at each rising edge, reset included
`define Y2A_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define Y2A_ASSERT(label, clk, rst_n, prop, msg)
`define Y2A_ASSERT_NORST(label, clk, prop, msg)
`endif

`endif

[src/yuv2argb_pkg.sv]
// Shared types and constants of the packed 4:2:2 to ARGB converter.
// No dependencies; imported by the interfaces and every module.
`timescale 1ns / 1ps
`default_nettype none

package yuv2argb_pkg;

  // configuration port
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 14;
  localparam int FRAME_DIM_W = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PACKING_MODE = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_idx_e;

  localparam logic [FRAME_DIM_W-1:0] FRAME_WIDTH_RESET  = 14'd1920;
  localparam logic [FRAME_DIM_W-1:0] FRAME_HEIGHT_RESET = 14'd1080;

  // in UYVY mode, HD matrix is chosen at or above either size
  localparam logic [FRAME_DIM_W-1:0] HD_MIN_WIDTH  = 14'd1280;
  localparam logic [FRAME_DIM_W-1:0] HD_MIN_HEIGHT = 14'd720;

  localparam int DEFAULT_MAX_WIDTH = 8192;

  // fixed-point conversion, scale 256
  localparam int COEF_W = 11;
  localparam int SUM_W  = 20;

  typedef logic signed [SUM_W-1:0] sum_t;

  localparam logic signed [COEF_W-1:0] K_LUMA     = 11'sd298;
  localparam logic signed [COEF_W-1:0] K601_R_V   = 11'sd409;
  localparam logic signed [COEF_W-1:0] K601_G_U   = 11'sd100;
  localparam logic signed [COEF_W-1:0] K601_G_V   = 11'sd208;
  localparam logic signed [COEF_W-1:0] K601_B_U   = 11'sd516;
  localparam logic signed [COEF_W-1:0] K709_R_V   = 11'sd459;
  localparam logic signed [COEF_W-1:0] K709_G_U   = 11'sd55;
  localparam logic signed [COEF_W-1:0] K709_G_V   = 11'sd136;
  localparam logic signed [COEF_W-1:0] K709_B_U   = 11'sd541;
  localparam logic signed [SUM_W-1:0]  ROUND_HALF = 20'sd128;
  localparam logic [7:0]               LUMA_OFS   = 8'd16;
  localparam logic [7:0]               CHROMA_OFS = 8'd128;

  typedef struct packed {
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
    logic [7:0] byte_d;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] first_blue;
    logic [7:0] first_green;
    logic [7:0] first_red;
    logic [7:0] second_blue;
    logic [7:0] second_green;
    logic [7:0] second_red;
    logic       second_valid;
    logic       row_end;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  // what the product stage hands to the output stage besides pixels
  typedef struct packed {
    logic valid;
    logic second_valid;
    logic row_end;
  } stage_t;

endpackage

`default_nettype wire

[src/yuv2argb_if.sv]
// Valid/ready stream interfaces for the input macropixel and output pixel pair.
// Depends on yuv2argb_pkg for the beat types.
`timescale 1ns / 1ps
`default_nettype none

interface yuv2argb_in_if import yuv2argb_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface yuv2argb_out_if import yuv2argb_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/packed_yuv422_to_argb.sv]
// Packed 4:2:2 macropixel to two BGR pixels; uses yuv2argb_pkg, interfaces, lane, merge.
// Throughput: one macropixel beat per cycle while the output is not stalled, set by the two lanes working side by side.
// Pipeline: lane product register, then the output register.
// Reset: configuration returns to YUY2, 1920 x 1080; column to zero; pipeline empty.
`timescale 1ns / 1ps
`default_nettype none
`include "packed_yuv422_to_argb_defines.svh"

module packed_yuv422_to_argb import yuv2argb_pkg::*; #(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  yuv2argb_in_if.sink           in_i,
  yuv2argb_out_if.source        out_o
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CMP_W = ((COL_W > FRAME_DIM_W) ? COL_W : FRAME_DIM_W) + 2;

  logic                   mode_q;
  logic [FRAME_DIM_W-1:0] width_q, height_q;
  logic [COL_W-1:0]       col_d, col_q;
  logic                   s1_valid_d, s1_valid_q;
  logic                   s1_second_q, s1_row_end_q;
  logic                   advance;
  logic                   in_fire;
  logic                   hd;
  logic [7:0]             y0, y1, u, v;
  logic [CMP_W-1:0]       w_lim, width_ext, max_ext, x_ext;
  logic                   second_ok, last;
  stage_t                 s1;
  pix_t                   pix_first, pix_second;

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      width_q  <= FRAME_WIDTH_RESET;
      height_q <= FRAME_HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PACKING_MODE: mode_q   <= cfg_data_i[0];
        CFG_FRAME_WIDTH:  width_q  <= cfg_data_i[FRAME_DIM_W-1:0];
        CFG_FRAME_HEIGHT: height_q <= cfg_data_i[FRAME_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // unpack the macropixel and choose the matrix
  always_comb begin
    if (mode_q) begin
      u  = in_i.data.byte_a;
      y0 = in_i.data.byte_b;
      v  = in_i.data.byte_c;
      y1 = in_i.data.byte_d;
    end else begin
      y0 = in_i.data.byte_a;
      u  = in_i.data.byte_b;
      y1 = in_i.data.byte_c;
      v  = in_i.data.byte_d;
    end
    hd = mode_q && ((width_q >= HD_MIN_WIDTH) || (height_q >= HD_MIN_HEIGHT));
  end

  // row position: saturate width, flag odd tail and row end
  always_comb begin
    width_ext = CMP_W'(width_q);
    max_ext   = CMP_W'(MAX_WIDTH);
    w_lim     = (width_ext > max_ext) ? max_ext : width_ext;
    x_ext     = CMP_W'(col_q);
    second_ok = (x_ext + CMP_W'(1)) < w_lim;
    last      = (x_ext + CMP_W'(2)) >= w_lim;
    col_d     = last ? '0 : col_q + COL_W'(2);
  end

  // accept when the product stage is empty or moving on
  assign in_i.ready = !s1_valid_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (in_fire) begin
        col_q <= col_d;
      end
    end
  end

  // carry row flags alongside the lane products
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_second_q  <= second_ok;
      s1_row_end_q <= last;
    end
  end

  assign s1.valid        = s1_valid_q;
  assign s1.second_valid = s1_second_q;
  assign s1.row_end      = s1_row_end_q;

  yuv2argb_lane u_lane_first (
    .clk_i      (clk_i),
    .load_i     (in_fire),
    .hd_i       (hd),
    .luma_i     (y0),
    .chroma_u_i (u),
    .chroma_v_i (v),
    .pix_o      (pix_first)
  );

  yuv2argb_lane u_lane_second (
    .clk_i      (clk_i),
    .load_i     (in_fire),
    .hd_i       (hd),
    .luma_i     (y1),
    .chroma_u_i (u),
    .chroma_v_i (v),
    .pix_o      (pix_second)
  );

  yuv2argb_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s1_i      (s1),
    .first_i   (pix_first),
    .second_i  (pix_second),
    .advance_o (advance),
    .out_o     (out_o)
  );

  // column always stays below MAX_WIDTH
  `Y2A_ASSERT_NORST(a_col_range, clk_i, CMP_W'(col_q) < CMP_W'(MAX_WIDTH), "column out of range")
  // row end returns the column to zero
  `Y2A_ASSERT(a_col_wrap, clk_i, rst_ni, (in_fire && last) |=> (col_q == '0), "column not cleared")
  // any other beat advances the column by two
  `Y2A_ASSERT(a_col_step, clk_i, rst_ni,
    (in_fire && !last) |=> (col_q == $past(col_q) + COL_W'(2)), "column step wrong")
  // a pending product beat waits while the output is blocked
  `Y2A_ASSERT(a_s1_hold, clk_i, rst_ni, (s1_valid_q && !advance) |=> s1_valid_q, "beat dropped")
  // only the last beat of a row can drop its second pixel
  `Y2A_ASSERT(a_second_tail, clk_i, rst_ni,
    (out_o.valid && !out_o.data.row_end) |-> out_o.data.second_valid, "odd tail mid-row")

endmodule

`default_nettype wire

[src/yuv2argb_lane.sv]
// One conversion lane: Y/U/V to clamped BGR for a single pixel.
// Registers the products on load, then sums and clamps. Depends on yuv2argb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module yuv2argb_lane import yuv2argb_pkg::*; (
  input  logic       clk_i,
  input  logic       load_i,
  input  logic       hd_i,
  input  logic [7:0] luma_i,
  input  logic [7:0] chroma_u_i,
  input  logic [7:0] chroma_v_i,
  output pix_t       pix_o
);

  // floor divide by 256 and clamp to a byte
  function automatic logic [7:0] to_byte(input sum_t v);
    logic [7:0] res;
    if (v[SUM_W-1]) begin
      res = 8'd0;
    end else if (|v[SUM_W-2:16]) begin
      res = 8'hFF;
    end else begin
      res = v[15:8];
    end
    return res;
  endfunction

  logic signed [9:0]        c_y, c_u, c_v;
  logic signed [COEF_W-1:0] k_rv, k_gu, k_gv, k_bu;
  sum_t py_d, pbu_d, pgu_d, pgv_d, prv_d;
  sum_t py_q, pbu_q, pgu_q, pgv_q, prv_q;
  sum_t sum_b, sum_g, sum_r;

  // remove offsets and pick the matrix
  always_comb begin
    c_y  = $signed({2'b00, luma_i})     - $signed({2'b00, LUMA_OFS});
    c_u  = $signed({2'b00, chroma_u_i}) - $signed({2'b00, CHROMA_OFS});
    c_v  = $signed({2'b00, chroma_v_i}) - $signed({2'b00, CHROMA_OFS});
    k_rv = hd_i ? K709_R_V : K601_R_V;
    k_gu = hd_i ? K709_G_U : K601_G_U;
    k_gv = hd_i ? K709_G_V : K601_G_V;
    k_bu = hd_i ? K709_B_U : K601_B_U;
  end

  // form the products
  always_comb begin
    py_d  = sum_t'(c_y) * sum_t'(K_LUMA);
    pbu_d = sum_t'(c_u) * sum_t'(k_bu);
    pgu_d = sum_t'(c_u) * sum_t'(k_gu);
    pgv_d = sum_t'(c_v) * sum_t'(k_gv);
    prv_d = sum_t'(c_v) * sum_t'(k_rv);
  end

  // hold products for the output stage
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      py_q  <= py_d;
      pbu_q <= pbu_d;
      pgu_q <= pgu_d;
      pgv_q <= pgv_d;
      prv_q <= prv_d;
    end
  end

  // sum, round and clamp each channel
  always_comb begin
    sum_b       = py_q + pbu_q + ROUND_HALF;
    sum_g       = py_q - pgu_q - pgv_q + ROUND_HALF;
    sum_r       = py_q + prv_q + ROUND_HALF;
    pix_o.blue  = to_byte(sum_b);
    pix_o.green = to_byte(sum_g);
    pix_o.red   = to_byte(sum_r);
  end

endmodule

`default_nettype wire

[src/yuv2argb_merge.sv]
// Output stage: joins the two lane pixels and row flags into one output beat.
// Holds the beat until taken. Depends on yuv2argb_pkg and yuv2argb_out_if.
`timescale 1ns / 1ps
`default_nettype none

module yuv2argb_merge import yuv2argb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  stage_t          s1_i,
  input  pix_t            first_i,
  input  pix_t            second_i,
  output logic            advance_o,
  yuv2argb_out_if.source  out_o
);

  logic      out_valid_d, out_valid_q;
  out_beat_t beat_d, beat_q;

  // output register is free when empty or being taken
  assign advance_o = !out_valid_q || out_o.ready;

  always_comb begin
    out_valid_d         = advance_o ? s1_i.valid : out_valid_q;
    beat_d.first_blue   = first_i.blue;
    beat_d.first_green  = first_i.green;
    beat_d.first_red    = first_i.red;
    beat_d.second_blue  = second_i.blue;
    beat_d.second_green = second_i.green;
    beat_d.second_red   = second_i.red;
    beat_d.second_valid = s1_i.second_valid;
    beat_d.row_end      = s1_i.row_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // capture a new beat when the product stage moves on
  always_ff @(posedge clk_i) begin
    if (advance_o && s1_i.valid) begin
      beat_q <= beat_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = beat_q;

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking bench for the packed 4:2:2 to BGR pixel-pair converter.
// Predicts each pixel pair, row end and odd-pixel mask; depends on yuv2argb_pkg,
// the stream interfaces and the packed_yuv422_to_argb top level.
`timescale 1ns / 1ps

module testbench;
  import yuv2argb_pkg::*;

  localparam int ROW_LIMIT = 8192;
  localparam bit PACK_YUY2 = 1'b0;
  localparam bit PACK_UYVY = 1'b1;
  localparam int MAX_REPORTS = 10;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  yuv2argb_in_if  in_bus ();
  yuv2argb_out_if out_bus ();

  packed_yuv422_to_argb uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  // shadow of the converter's registers and column counter
  bit                     model_uyvy;
  logic [FRAME_DIM_W-1:0] model_width;
  logic [FRAME_DIM_W-1:0] model_height;
  int unsigned            model_column;

  out_beat_t   expected_pairs[$];
  out_beat_t   oldest_pair;
  int unsigned beats_sent;
  int unsigned pairs_checked;
  int unsigned rows_closed;
  int unsigned odd_masked;
  int unsigned settings_used;
  int unsigned mismatch_count;
  bit          sender_idle;
  bit          sink_stalls;
  int unsigned sink_wait;

  always #4 clk_i = ~clk_i;

  // floor(acc / 256), clamped to one byte
  function automatic logic [7:0] clamp_to_byte(int acc);
    int q;
    q = acc >>> 8;
    if (q < 0) return 8'd0;
    if (q > 255) return 8'd255;
    return q[7:0];
  endfunction

  function automatic pix_t convert_pixel(logic [7:0] luma, logic [7:0] cb, logic [7:0] cr,
                                         bit hd);
    int   c;
    int   d;
    int   e;
    int   kr;
    int   kgu;
    int   kgv;
    int   kb;
    pix_t px;
    c   = int'(luma) - 16;
    d   = int'(cb) - 128;
    e   = int'(cr) - 128;
    kr  = hd ? 459 : 409;
    kgu = hd ? 55 : 100;
    kgv = hd ? 136 : 208;
    kb  = hd ? 541 : 516;
    px.blue  = clamp_to_byte(298 * c + kb * d + 128);
    px.green = clamp_to_byte(298 * c - kgu * d - kgv * e + 128);
    px.red   = clamp_to_byte(298 * c + kr * e + 128);
    return px;
  endfunction

  // compute the pixel pair of one macropixel and advance the column
  function automatic out_beat_t predict_pixel_pair(in_beat_t mp);
    logic [7:0]  y0;
    logic [7:0]  y1;
    logic [7:0]  cb;
    logic [7:0]  cr;
    bit          hd;
    int unsigned row_len;
    int unsigned col;
    pix_t        p0;
    pix_t        p1;
    out_beat_t   r;
    if (model_uyvy) begin
      cb = mp.byte_a;
      y0 = mp.byte_b;
      cr = mp.byte_c;
      y1 = mp.byte_d;
      hd = (model_width >= 14'd1280) || (model_height >= 14'd720);
    end else begin
      y0 = mp.byte_a;
      cb = mp.byte_b;
      y1 = mp.byte_c;
      cr = mp.byte_d;
      hd = 1'b0;
    end
    row_len = (model_width > ROW_LIMIT) ? ROW_LIMIT : model_width;
    col = model_column;
    p0 = convert_pixel(y0, cb, cr, hd);
    p1 = convert_pixel(y1, cb, cr, hd);
    r.first_blue   = p0.blue;
    r.first_green  = p0.green;
    r.first_red    = p0.red;
    r.second_blue  = p1.blue;
    r.second_green = p1.green;
    r.second_red   = p1.red;
    r.second_valid = (col + 1 < row_len);
    r.row_end      = (col + 2 >= row_len);
    model_column = r.row_end ? 0 : col + 2;
    return r;
  endfunction

  function automatic logic [7:0] random_byte();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0: v = 8'd0;
      1: v = 8'd255;
      2: v = 8'd16;
      3: v = 8'd235;
      default: ;
    endcase
    return v;
  endfunction

  function automatic in_beat_t random_macropixel();
    in_beat_t mp;
    mp.byte_a = random_byte();
    mp.byte_b = random_byte();
    mp.byte_c = random_byte();
    mp.byte_d = random_byte();
    return mp;
  endfunction

  function automatic void check_field(string label, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("pair %0d: %s expected %0d, got %0d", pairs_checked, label, want, got);
    end
  endfunction

  // hold the beat until the converter takes it, then record its pixel pair
  task automatic send_macropixel(input in_beat_t mp);
    int unsigned gap;
    gap = sender_idle ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= mp;
    do @(posedge clk_i); while (!in_bus.ready);
    expected_pairs.push_back(predict_pixel_pair(mp));
    beats_sent++;
  endtask

  // drop valid and hold until every pixel pair has come back
  task automatic wait_for_results();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_pairs.size() != 0) @(posedge clk_i);
  endtask

  // write all three registers; only called with the pipeline empty
  task automatic apply_config(input bit mode, input logic [FRAME_DIM_W-1:0] w,
                              input logic [FRAME_DIM_W-1:0] h);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_PACKING_MODE;
    cfg_data_i <= {{(CFG_DATA_W-1){1'b0}}, mode};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_FRAME_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_FRAME_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model_uyvy   = mode;
    model_width  = w;
    model_height = h;
    settings_used++;
  endtask

  // color extremes under the reset setting: YUY2, 1920 x 1080
  task automatic test_reset_defaults();
    send_macropixel(in_beat_t'{8'd0, 8'd0, 8'd0, 8'd0});
    send_macropixel(in_beat_t'{8'd255, 8'd255, 8'd255, 8'd255});
    send_macropixel(in_beat_t'{8'd16, 8'd128, 8'd235, 8'd128});
    send_macropixel(in_beat_t'{8'd81, 8'd90, 8'd81, 8'd240});
    send_macropixel(in_beat_t'{8'd0, 8'd255, 8'd255, 8'd0});
    send_macropixel(in_beat_t'{8'd255, 8'd0, 8'd0, 8'd255});
  endtask

  // UYVY order: HD matrix by width or by height, SD just below both
  task automatic test_matrix_choice();
    wait_for_results();
    apply_config(PACK_UYVY, 14'd1920, 14'd1080);
    send_macropixel(in_beat_t'{8'd255, 8'd16, 8'd0, 8'd235});
    send_macropixel(in_beat_t'{8'd0, 8'd255, 8'd255, 8'd0});
    wait_for_results();
    apply_config(PACK_UYVY, 14'd1279, 14'd719);
    send_macropixel(in_beat_t'{8'd255, 8'd16, 8'd0, 8'd235});
    send_macropixel(in_beat_t'{8'd0, 8'd255, 8'd255, 8'd0});
    wait_for_results();
    apply_config(PACK_UYVY, 14'd1280, 14'd1);
    send_macropixel(in_beat_t'{8'd90, 8'd81, 8'd240, 8'd145});
    wait_for_results();
    apply_config(PACK_UYVY, 14'd1, 14'd720);
    send_macropixel(in_beat_t'{8'd90, 8'd81, 8'd240, 8'd145});
  endtask

  // odd width, one- and zero-pixel rows, width shrunk below the column
  task automatic test_row_edges();
    wait_for_results();
    apply_config(PACK_YUY2, 14'd5, 14'd1080);
    repeat (3) send_macropixel(random_macropixel());
    wait_for_results();
    apply_config(PACK_YUY2, 14'd1, 14'd1080);
    send_macropixel(random_macropixel());
    wait_for_results();
    apply_config(PACK_UYVY, 14'd0, 14'd0);
    repeat (2) send_macropixel(random_macropixel());
    wait_for_results();
    apply_config(PACK_YUY2, 14'd2, 14'd1080);
    repeat (2) send_macropixel(random_macropixel());
    wait_for_results();
    apply_config(PACK_YUY2, 14'd10, 14'd1080);
    repeat (3) send_macropixel(random_macropixel());
    wait_for_results();
    apply_config(PACK_YUY2, 14'd4, 14'd1080);
    repeat (2) send_macropixel(random_macropixel());
  endtask

  // random macropixels over many settings, one mid-phase drain each
  task automatic test_random_phases();
    int                     phase;
    int                     n;
    int                     pause_at;
    bit                     mode;
    logic [FRAME_DIM_W-1:0] w;
    logic [FRAME_DIM_W-1:0] h;
    for (phase = 0; phase < 14; phase++) begin
      mode = 1'($urandom_range(0, 1));
      w = FRAME_DIM_W'($urandom_range(1, 48));
      h = FRAME_DIM_W'($urandom_range(1, 8192));
      case (phase)
        0: w = 14'd0;
        1: w = 14'd1;
        2: begin
          w = 14'd8192;
          h = 14'd8192;
        end
        3: begin
          w = 14'h3FFF;
          h = 14'h3FFF;
        end
        4: begin
          w = 14'd2;
          h = 14'd0;
        end
        5: begin
          mode = PACK_UYVY;
          w = 14'd1279;
          h = 14'd719;
        end
        6: begin
          mode = PACK_UYVY;
          w = FRAME_DIM_W'($urandom_range(1280, 4000));
        end
        default: ;
      endcase
      sender_idle = (phase != 7) && ($urandom_range(0, 3) != 0);
      sink_stalls = (phase != 7) && ($urandom_range(0, 3) != 0);
      wait_for_results();
      apply_config(mode, w, h);
      pause_at = $urandom_range(10, 50);
      for (n = 0; n < 56; n++) begin
        if (n == pause_at) wait_for_results();
        send_macropixel(random_macropixel());
      end
    end
  endtask

  // raw width above the row limit: no early row end, HD matrix by raw width
  task automatic test_width_saturation();
    wait_for_results();
    sender_idle = 1'b0;
    sink_stalls = 1'b0;
    apply_config(PACK_UYVY, 14'h3FFF, 14'd1);
    repeat (40) send_macropixel(random_macropixel());
  endtask

  // check each accepted pixel pair and draw the next stall
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      sink_wait = 0;
    end else if (out_bus.valid && out_bus.ready) begin
      if (expected_pairs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("pixel pair %h arrived with nothing expected", out_bus.data);
      end else begin
        oldest_pair = expected_pairs.pop_front();
        check_field("first_blue", oldest_pair.first_blue, out_bus.data.first_blue);
        check_field("first_green", oldest_pair.first_green, out_bus.data.first_green);
        check_field("first_red", oldest_pair.first_red, out_bus.data.first_red);
        check_field("second_blue", oldest_pair.second_blue, out_bus.data.second_blue);
        check_field("second_green", oldest_pair.second_green, out_bus.data.second_green);
        check_field("second_red", oldest_pair.second_red, out_bus.data.second_red);
        check_field("second_valid", 8'(oldest_pair.second_valid),
                    8'(out_bus.data.second_valid));
        check_field("row_end", 8'(oldest_pair.row_end), 8'(out_bus.data.row_end));
        if (oldest_pair.row_end) rows_closed++;
        if (!oldest_pair.second_valid) odd_masked++;
        pairs_checked++;
      end
      sink_wait = sink_stalls ? $urandom_range(0, 8) : 0;
      if (sink_wait != 0) out_bus.ready <= 1'b0;
    end else if (!out_bus.ready) begin
      if (sink_wait != 0) sink_wait--;
      if (sink_wait == 0) out_bus.ready <= 1'b1;
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_PACKING_MODE;
    cfg_data_i    = '0;
    in_bus.valid  = 1'b0;
    in_bus.data   = '0;
    out_bus.ready = 1'b0;
    model_uyvy    = PACK_YUY2;
    model_width   = 14'd1920;
    model_height  = 14'd1080;
    model_column  = 0;
    sender_idle   = 1'b1;
    sink_stalls   = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_matrix_choice();
    test_row_edges();
    test_random_phases();
    test_width_saturation();

    wait_for_results();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d macropixels over %0d register settings; checked %0d pixel pairs.",
             beats_sent, settings_used + 1, pairs_checked);
    $display("Saw %0d row ends and %0d masked odd pixels; %0d field errors.",
             rows_closed, odd_masked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // stop a hung run
  initial begin
    #2000000;
    $display("Timed out with %0d pixel pairs outstanding.", expected_pairs.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
